[hdl/euler_to_quaternion_top_macros.svh]
// Assertion macros for the Euler-to-quaternion block.
`ifndef EULER_TO_QUATERNION_TOP_MACROS_SVH
`define EULER_TO_QUATERNION_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ETQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ETQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/etq_pkg.sv]
//------------------------------------------------------------------------------
// etq_pkg
// Types, widths and constants shared by the Euler-to-quaternion pipeline.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package etq_pkg;

    // Number of CORDIC iterations, one pipeline stage each.
    localparam int CORDIC_STEPS = 24;

    // Width of the CORDIC x/y datapath (Q30) and of the angle accumulator (Q32).
    localparam int XW = 34;
    localparam int ZW = 36;

    // Stages inside one angle lane and in the whole pipeline.
    localparam int LANE_STAGES = CORDIC_STEPS + 5;
    localparam int PIPE_STAGES = LANE_STAGES + 3;

    // Scale from an angle to a half-turn phase fraction.
    localparam logic [44:0] K_DEG = 45'd390937467654;
    localparam logic [44:0] K_RAD = 45'h145F306DC9C9;

    // Pi in Q30 and the CORDIC gain start value in Q30.
    localparam logic signed [32:0] PI_Q30   = 33'sh0C90FDAA2;
    localparam logic signed [XW-1:0] GAIN_Q30 = 34'sh026DD3B6A;

    typedef logic signed [31:0]   angle_t;
    typedef logic signed [31:0]   quat_t;
    typedef logic signed [XW-1:0] coord_t;

    // Unsigned shift-subtract division, used only at elaboration.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Arctangent of 2^-i in Q32, from the alternating series in Q62.
    function automatic logic signed [ZW-1:0] atan_q32(input int i);
        longint acc;
        longint term;
        int     sh;
        logic signed [63:0] rounded;
        acc = 0;
        if (i == 0)
        begin
            return ZW'(PI_Q30);
        end
        for (int k = 0; k < 64; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh <= 62)
            begin
                term = longint'(udiv64(64'd1 << (62 - sh), longint'(2 * k + 1)));
                acc = (k % 2 == 1) ? acc - term : acc + term;
            end
        end
        rounded = (64'(acc) + 64'sd536870912) >>> 30;
        return rounded[ZW-1:0];
    endfunction

    // Round a Q60 product to Q30.
    function automatic logic signed [XW-1:0] rnd30(input logic signed [2*XW-1:0] v);
        logic signed [2*XW-1:0] t;
        t = (v + (2*XW)'(64'sd536870912)) >>> 30;
        return t[XW-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/etq_if.sv]
//------------------------------------------------------------------------------
// etq_if
// Valid/ready stream interfaces for the angle input and quaternion output.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface etq_angle_if;
    import etq_pkg::*;

    logic   valid;
    logic   ready;
    angle_t angle_pitch;
    angle_t angle_roll;
    angle_t angle_yaw;

    modport source (output valid, output angle_pitch, output angle_roll,
                    output angle_yaw, input ready);
    modport sink   (input valid, input angle_pitch, input angle_roll,
                    input angle_yaw, output ready);
endinterface

interface etq_quat_if;
    import etq_pkg::*;

    logic  valid;
    logic  ready;
    quat_t quat_w;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

`default_nettype wire

[hdl/etq_lane.sv]
//------------------------------------------------------------------------------
// etq_lane
// One angle: phase reduction, quadrant split and a pipelined CORDIC that
// gives the cosine and sine of the half angle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module etq_lane (
    input  wire logic                                   clk,
    input  wire logic [etq_pkg::LANE_STAGES-1:0]        stage_en,
    input  wire logic                                   unit_rad,
    input  wire etq_pkg::angle_t                        angle,
    output etq_pkg::coord_t                             cos_out,
    output etq_pkg::coord_t                             sin_out
);
    import etq_pkg::*;

    // Stage 1: split 32 x 45 product into two partial products.
    logic [44:0]         k_sel;
    logic signed [55:0]  plo_next;
    logic signed [55:0]  phi_next;
    logic signed [55:0]  plo_reg;
    logic signed [55:0]  phi_reg;

    assign k_sel    = unit_rad ? K_RAD : K_DEG;
    assign plo_next = 56'(angle * $signed({1'b0, k_sel[22:0]}));
    assign phi_next = 56'(angle * $signed({2'b00, k_sel[44:23]}));

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
    end

    // Stage 2: recombine, round and keep the turn fraction.
    logic [63:0] sum64;
    logic [31:0] phase_next;
    logic [31:0] phase_reg;

    assign sum64 = 64'(plo_reg) + (64'(phi_reg) << 23) + 64'h8000_0000;
    assign phase_next = sum64[63:32];

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            phase_reg <= phase_next;
        end
    end

    // Stage 3: quadrant and residual, residual scaled to radians.
    logic [31:0]        biased;
    logic signed [30:0] resid_wide;
    logic signed [29:0] resid;
    logic signed [62:0] rprod_next;
    logic signed [62:0] rprod_reg;
    logic [1:0]         quad_reg [0:CORDIC_STEPS+1];

    assign biased     = phase_reg + 32'h2000_0000;
    assign resid_wide = $signed({1'b0, biased[29:0]}) - 31'sd536870912;
    assign resid      = resid_wide[29:0];
    assign rprod_next = 63'(resid * PI_Q30);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            rprod_reg   <= rprod_next;
            quad_reg[0] <= biased[31:30];
        end
    end

    // Stage 4: CORDIC start values.
    logic signed [62:0]   zround;
    coord_t               x_reg [0:CORDIC_STEPS];
    coord_t               y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];

    assign zround = (rprod_reg + 63'sd268435456) >>> 29;

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= zround[ZW-1:0];
            quad_reg[1] <= quad_reg[0];
        end
    end

    // CORDIC iterations, one per stage.
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        localparam logic signed [ZW-1:0] ATAN = atan_q32(k);
        coord_t dx;
        coord_t dy;

        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;

        always_ff @(posedge clk)
        begin
            if (stage_en[4+k])
            begin
                if (!z_reg[k][ZW-1])
                begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - ATAN;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + ATAN;
                end
                quad_reg[k+2] <= quad_reg[k+1];
            end
        end
    end

    // Last stage: map the quadrant back onto cosine and sine.
    coord_t cos_next;
    coord_t sin_next;
    coord_t cos_reg;
    coord_t sin_reg;
    coord_t xf;
    coord_t yf;

    assign xf = x_reg[CORDIC_STEPS];
    assign yf = y_reg[CORDIC_STEPS];

    always_comb
    begin
        unique case (quad_reg[CORDIC_STEPS+1])
            2'd0:
            begin
                cos_next = xf;
                sin_next = yf;
            end
            2'd1:
            begin
                cos_next = -yf;
                sin_next = xf;
            end
            2'd2:
            begin
                cos_next = -xf;
                sin_next = -yf;
            end
            default:
            begin
                cos_next = yf;
                sin_next = -xf;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[LANE_STAGES-1])
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

`default_nettype wire

[hdl/euler_to_quaternion_top.sv]
//------------------------------------------------------------------------------
// euler_to_quaternion_top
// Euler angles (Q16.16) to unit quaternion (Q2.30), fully pipelined.
//------------------------------------------------------------------------------
// Usage:
// - angle: sink channel carrying pitch, roll and yaw; one transfer per item.
// - quat: source channel carrying w, x, y, z; one transfer per item.
// - cfg_wr_en/cfg_wr_data: bit 0 selects the angle unit (0 degrees,
//   1 radians); write it only while the pipeline is empty.
// - Each angle lane has 29 stages (two-part phase product, phase sum,
//   residual product, CORDIC start, 24 CORDIC steps, quadrant map),
//   followed by three stages of pair products, triple products and sums.
// - Throughput is one item per cycle while the receiver is not stalling;
//   every stage is a register with its own valid bit.
// - A stalled receiver holds the output; upstream stages keep accepting
//   until every stage is occupied, so empty slots are squeezed out.
// - Reset clears all valid bits and sets the unit to degrees.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "euler_to_quaternion_top_macros.svh"

module euler_to_quaternion_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_wr_en,
    input  wire logic    cfg_wr_data,
    etq_angle_if.sink    angle,
    etq_quat_if.source   quat
);
    import etq_pkg::*;

    // Unit configuration register.
    logic angle_unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_unit_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            angle_unit_reg <= cfg_wr_data;
        end
    end

    // Per-stage load enables: a stage loads when empty or being drained.
    logic [PIPE_STAGES:0]   load;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_in;

    always_comb
    begin
        load[PIPE_STAGES] = quat.ready;
        for (int i = PIPE_STAGES - 1; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign vld_in = {vld_reg[PIPE_STAGES-2:0], angle.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < PIPE_STAGES; i++)
            begin
                if (load[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    assign angle.ready = load[0];

    // Three angle lanes.
    coord_t cp;
    coord_t sp;
    coord_t cr;
    coord_t sr;
    coord_t cy;
    coord_t sy;

    etq_lane u_lane_pitch (
        .clk      (clk),
        .stage_en (load[LANE_STAGES-1:0]),
        .unit_rad (angle_unit_reg),
        .angle    (angle.angle_pitch),
        .cos_out  (cp),
        .sin_out  (sp)
    );

    etq_lane u_lane_roll (
        .clk      (clk),
        .stage_en (load[LANE_STAGES-1:0]),
        .unit_rad (angle_unit_reg),
        .angle    (angle.angle_roll),
        .cos_out  (cr),
        .sin_out  (sr)
    );

    etq_lane u_lane_yaw (
        .clk      (clk),
        .stage_en (load[LANE_STAGES-1:0]),
        .unit_rad (angle_unit_reg),
        .angle    (angle.angle_yaw),
        .cos_out  (cy),
        .sin_out  (sy)
    );

    // Product stage 1: pitch-roll pair products, rounded to Q30.
    coord_t pcc_reg;
    coord_t pss_reg;
    coord_t psc_reg;
    coord_t pcs_reg;
    coord_t cy_reg;
    coord_t sy_reg;

    always_ff @(posedge clk)
    begin
        if (load[LANE_STAGES])
        begin
            pcc_reg <= rnd30((2*XW)'(cp * cr));
            pss_reg <= rnd30((2*XW)'(sp * sr));
            psc_reg <= rnd30((2*XW)'(sp * cr));
            pcs_reg <= rnd30((2*XW)'(cp * sr));
            cy_reg  <= cy;
            sy_reg  <= sy;
        end
    end

    // Product stage 2: the eight triple products.
    logic signed [2*XW-1:0] t_reg [0:7];

    always_ff @(posedge clk)
    begin
        if (load[LANE_STAGES+1])
        begin
            t_reg[0] <= pcc_reg * cy_reg;
            t_reg[1] <= pss_reg * sy_reg;
            t_reg[2] <= psc_reg * cy_reg;
            t_reg[3] <= pcs_reg * sy_reg;
            t_reg[4] <= pcs_reg * cy_reg;
            t_reg[5] <= psc_reg * sy_reg;
            t_reg[6] <= pcc_reg * sy_reg;
            t_reg[7] <= pss_reg * cy_reg;
        end
    end

    // Product stage 3: round, sum and register the result.
    coord_t w_next;
    coord_t x_next;
    coord_t y_next;
    coord_t z_next;
    quat_t  w_reg;
    quat_t  x_reg;
    quat_t  y_reg;
    quat_t  z_reg;

    assign w_next = rnd30(t_reg[0]) + rnd30(t_reg[1]);
    assign x_next = rnd30(t_reg[2]) - rnd30(t_reg[3]);
    assign y_next = rnd30(t_reg[4]) + rnd30(t_reg[5]);
    assign z_next = rnd30(t_reg[6]) - rnd30(t_reg[7]);

    always_ff @(posedge clk)
    begin
        if (load[PIPE_STAGES-1])
        begin
            w_reg <= w_next[31:0];
            x_reg <= x_next[31:0];
            y_reg <= y_next[31:0];
            z_reg <= z_next[31:0];
        end
    end

    assign quat.valid  = vld_reg[PIPE_STAGES-1];
    assign quat.quat_w = w_reg;
    assign quat.quat_x = x_reg;
    assign quat.quat_y = y_reg;
    assign quat.quat_z = z_reg;

    // Checks on the stage control.
    `ETQ_ASSERT_NEXT(a_in_lands, clk, rst_n, angle.valid && angle.ready, vld_reg[0], "accepted item missing from first stage")
    `ETQ_ASSERT_NOW(a_full_when_blocked, clk, rst_n, !angle.ready, &vld_reg, "input blocked while a stage is empty")
    `ETQ_ASSERT_NEXT(a_held_stage, clk, rst_n, vld_reg[0] && !load[1], vld_reg[0], "held item dropped from first stage")

endmodule

`default_nettype wire
